/* rtl/core/message_mailbox_fifo_assert.svh */
// Assertion macros shared by the mailbox checker.
// Depends on nothing; included by file name where assertions are written.
`ifndef MESSAGE_MAILBOX_FIFO_ASSERT_SVH
`define MESSAGE_MAILBOX_FIFO_ASSERT_SVH

// Check a property on every clock edge, including during reset.
`define MMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check a property only while the active-low reset is released.
`define MMF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* rtl/core/mmf_pkg.sv */
// Shared sizes, codes and structs for the message mailbox.
// Depends on nothing; imported by every mailbox module.
package mmf_pkg;

    localparam int SLOTS       = 16;
    localparam int MSG_BYTES   = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int IDX_W  = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
    localparam int CNT_W  = $clog2(MSG_BYTES + 2);
    localparam int ADDR_W = $clog2(SLOTS * MSG_BYTES);
    localparam int LEN_W  = 7;
    localparam int SND_W  = 16;
    localparam int KIND_W = 32;
    localparam int BYTE_W = 8;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd_code;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

    // Writes from the front into the slot stores.
    typedef struct packed {
        logic                byte_en;
        logic [ADDR_W-1:0]   byte_addr;
        logic [BYTE_W-1:0]   byte_data;
        logic                meta_en;
        logic [SLOT_W-1:0]   meta_slot;
        logic [SND_W-1:0]    sender;
        logic [KIND_W-1:0]   kind;
        logic [LEN_W-1:0]    length;
    } t_slot_wr;

    // Work handed from front to back: a plain status result or a delivery.
    typedef struct packed {
        logic                is_pop;
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [LEN_W-1:0]    cap;
    } t_cmd;

    typedef struct packed {
        t_status             status;
        logic [SND_W-1:0]    sender;
        logic [KIND_W-1:0]   kind;
        logic [LEN_W-1:0]    dlen;
        logic [BYTE_W-1:0]   data;
        logic                data_valid;
        logic                last;
    } t_result;

    function automatic logic [ADDR_W-1:0] byte_addr(input logic [SLOT_W-1:0] slot,
                                                    input logic [IDX_W-1:0]  idx);
        byte_addr = ADDR_W'(int'(slot) * MSG_BYTES + int'(idx));
    endfunction

endpackage

/* rtl/core/mmf_cmd_queue.sv */
// Short command queue between the mailbox front and back.
// Depends on mmf_pkg.
module mmf_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  mmf_pkg::t_cmd i_wr_data,
    input  logic          i_rd_en,
    output mmf_pkg::t_cmd o_rd_data,
    output logic          o_full,
    output logic          o_empty
);
    import mmf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_buf [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic [PTR_W-1:0]  n_wp;
    logic [PTR_W-1:0]  n_rp;
    logic [QCNT_W-1:0] n_cnt;

    assign o_full    = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_rd_data = r_buf[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_wr_en) begin
            n_wp = (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (i_rd_en) begin
            n_rp = (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        if (i_wr_en && !i_rd_en) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!i_wr_en && i_rd_en) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_buf[r_wp] <= i_wr_data;
        end
    end

endmodule

/* rtl/core/mmf_front.sv */
// Mailbox front: accepts items, streams bytes into the slot store, closes
// pushes and classifies pops. Depends on mmf_pkg.
module mmf_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic                         i_cmd,
    input  logic [mmf_pkg::SND_W-1:0]    i_sender_id,
    input  logic signed [mmf_pkg::KIND_W-1:0] i_message_kind,
    input  logic [mmf_pkg::BYTE_W-1:0]   i_payload_byte,
    input  logic                         i_byte_present,
    input  logic                         i_final_item,
    input  logic [mmf_pkg::LEN_W-1:0]    i_receive_capacity,
    input  logic                         i_q_full,
    output logic                         o_q_wr,
    output mmf_pkg::t_cmd                o_q_data,
    output mmf_pkg::t_slot_wr            o_slot_wr,
    input  logic                         i_pop_done
);
    import mmf_pkg::*;

    logic [SLOT_W-1:0] r_wslot;
    logic [SLOT_W-1:0] r_rslot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_pop_busy;
    logic [SLOT_W-1:0] n_wslot;
    logic [SLOT_W-1:0] n_rslot;
    logic [CNT_W-1:0]  n_cnt;
    logic              n_pop_busy;

    logic              accept;
    logic              is_pop;
    logic [CNT_W-1:0]  cnt_after;
    logic [SLOT_W-1:0] w_next;
    logic [SLOT_W-1:0] r_next;

    // Hold new items while a delivery still reads the slot store or the command queue is full.
    assign o_full = i_q_full || r_pop_busy;
    assign accept = i_push && !o_full;
    assign is_pop = (t_cmd_code'(i_cmd) == CMD_POP);

    assign cnt_after = (i_byte_present && (r_cnt <= CNT_W'(MSG_BYTES))) ?
                       r_cnt + CNT_W'(1) : r_cnt;
    assign w_next = (r_wslot == SLOT_W'(SLOTS - 1)) ? '0 : r_wslot + SLOT_W'(1);
    assign r_next = (r_rslot == SLOT_W'(SLOTS - 1)) ? '0 : r_rslot + SLOT_W'(1);

    always_comb begin
        n_wslot    = r_wslot;
        n_rslot    = r_rslot;
        n_cnt      = r_cnt;
        n_pop_busy = r_pop_busy;
        o_q_wr     = 1'b0;
        o_q_data   = '0;
        o_slot_wr  = '0;

        if (i_pop_done) begin
            n_pop_busy = 1'b0;
        end

        if (accept) begin
            if (!is_pop) begin
                o_slot_wr.byte_en   = i_byte_present && (r_cnt < CNT_W'(MSG_BYTES));
                o_slot_wr.byte_addr = byte_addr(r_wslot, r_cnt[IDX_W-1:0]);
                o_slot_wr.byte_data = i_payload_byte;
                n_cnt = cnt_after;
                if (i_final_item) begin
                    n_cnt  = '0;
                    o_q_wr = 1'b1;
                    priority if (cnt_after > CNT_W'(MSG_BYTES)) begin
                        o_q_data.status = ST_TOO_LONG;
                    end else if (w_next == r_rslot) begin
                        o_q_data.status = ST_FULL;
                    end else begin
                        o_q_data.status     = ST_OK;
                        o_slot_wr.meta_en   = 1'b1;
                        o_slot_wr.meta_slot = r_wslot;
                        o_slot_wr.sender    = i_sender_id;
                        o_slot_wr.kind      = $unsigned(i_message_kind);
                        o_slot_wr.length    = LEN_W'(cnt_after);
                        n_wslot             = w_next;
                    end
                end
            end else begin
                o_q_wr = 1'b1;
                if (r_wslot == r_rslot) begin
                    o_q_data.status = ST_EMPTY;
                end else begin
                    o_q_data.is_pop = 1'b1;
                    o_q_data.status = ST_OK;
                    o_q_data.slot   = r_rslot;
                    o_q_data.cap    = i_receive_capacity;
                    n_rslot         = r_next;
                    n_pop_busy      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot    <= '0;
            r_rslot    <= '0;
            r_cnt      <= '0;
            r_pop_busy <= 1'b0;
        end else begin
            r_wslot    <= n_wslot;
            r_rslot    <= n_rslot;
            r_cnt      <= n_cnt;
            r_pop_busy <= n_pop_busy;
        end
    end

endmodule

/* rtl/core/mmf_back.sv */
// Mailbox back: owns the slot stores, turns queued commands into results
// and holds them in a small output buffer. Depends on mmf_pkg.
module mmf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mmf_pkg::t_slot_wr i_slot_wr,
    input  mmf_pkg::t_cmd     i_q_head,
    input  logic              i_q_empty,
    output logic              o_q_rd,
    output logic              o_pop_done,
    input  logic              i_pop,
    output logic              o_empty,
    output mmf_pkg::t_result  o_result
);
    import mmf_pkg::*;

    localparam int OB_DEPTH = 2;
    localparam int OB_PTR_W = $clog2(OB_DEPTH);
    localparam int OB_CNT_W = $clog2(OB_DEPTH + 1);
    localparam int OCC_W    = $clog2(OB_DEPTH + 2);

    // Slot stores.
    logic [BYTE_W-1:0] r_mem_bytes  [SLOTS * MSG_BYTES];
    logic [SND_W-1:0]  r_mem_sender [SLOTS];
    logic [KIND_W-1:0] r_mem_kind   [SLOTS];
    logic [LEN_W-1:0]  r_mem_len    [SLOTS];

    t_back_state       r_state;
    t_back_state       n_state;
    logic [SLOT_W-1:0] r_slot;
    logic [LEN_W-1:0]  r_cap;
    logic [LEN_W-1:0]  r_idx;
    logic [SND_W-1:0]  r_meta_sender;
    logic [KIND_W-1:0] r_meta_kind;
    logic [LEN_W-1:0]  r_meta_len;
    logic [BYTE_W-1:0] r_rd_data;

    logic              r_a_valid;
    t_result           r_a;
    logic              r_a_ram;

    t_result             r_ob [OB_DEPTH];
    logic [OB_PTR_W-1:0] r_ob_wp;
    logic [OB_PTR_W-1:0] r_ob_rp;
    logic [OB_CNT_W-1:0] r_ob_cnt;

    logic              ob_pop;
    logic [OCC_W-1:0]  occ;
    logic              can_issue;
    logic [LEN_W-1:0]  n_len;
    logic              meta_rd;
    logic              rd_en;
    logic              iss;
    logic              iss_ram;
    t_result           iss_res;
    t_result           ob_in;

    assign ob_pop    = i_pop && (r_ob_cnt != '0);
    assign o_empty   = (r_ob_cnt == '0);
    assign o_result  = r_ob[r_ob_rp];
    assign occ       = OCC_W'(r_ob_cnt) + OCC_W'(r_a_valid) - OCC_W'(ob_pop);
    assign can_issue = (occ <= OCC_W'(OB_DEPTH - 1));
    assign n_len     = (r_meta_len < r_cap) ? r_meta_len : r_cap;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (meta_rd) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (o_pop_done) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_rd     = 1'b0;
        meta_rd    = 1'b0;
        rd_en      = 1'b0;
        iss        = 1'b0;
        iss_ram    = 1'b0;
        iss_res    = '0;
        o_pop_done = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty && can_issue) begin
                    o_q_rd = 1'b1;
                    if (i_q_head.is_pop) begin
                        meta_rd = 1'b1;
                    end else begin
                        iss            = 1'b1;
                        iss_res.status = i_q_head.status;
                        iss_res.last   = 1'b1;
                    end
                end
            end
            BK_EMIT: begin
                if (can_issue) begin
                    iss            = 1'b1;
                    iss_res.status = ST_OK;
                    iss_res.sender = r_meta_sender;
                    iss_res.kind   = r_meta_kind;
                    iss_res.dlen   = n_len;
                    if (n_len == '0) begin
                        iss_res.last = 1'b1;
                        o_pop_done   = 1'b1;
                    end else begin
                        rd_en              = 1'b1;
                        iss_ram            = 1'b1;
                        iss_res.data_valid = 1'b1;
                        iss_res.last       = (r_idx + LEN_W'(1) == n_len);
                        o_pop_done         = iss_res.last;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        ob_in = r_a;
        ob_in.data = r_a_ram ? r_rd_data : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_a_valid <= 1'b0;
            r_ob_wp   <= '0;
            r_ob_rp   <= '0;
            r_ob_cnt  <= '0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_a_valid <= iss;
            if (meta_rd) begin
                r_idx <= '0;
            end else if (rd_en) begin
                r_idx <= r_idx + LEN_W'(1);
            end
            if (r_a_valid) begin
                r_ob_wp <= (r_ob_wp == OB_PTR_W'(OB_DEPTH - 1)) ? '0 : r_ob_wp + OB_PTR_W'(1);
            end
            if (ob_pop) begin
                r_ob_rp <= (r_ob_rp == OB_PTR_W'(OB_DEPTH - 1)) ? '0 : r_ob_rp + OB_PTR_W'(1);
            end
            if (r_a_valid && !ob_pop) begin
                r_ob_cnt <= r_ob_cnt + OB_CNT_W'(1);
            end else if (!r_a_valid && ob_pop) begin
                r_ob_cnt <= r_ob_cnt - OB_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= iss_res;
        r_a_ram <= iss_ram;
        if (r_a_valid) begin
            r_ob[r_ob_wp] <= ob_in;
        end
        if (meta_rd) begin
            r_slot <= i_q_head.slot;
            r_cap  <= i_q_head.cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_slot_wr.byte_en) begin
            r_mem_bytes[i_slot_wr.byte_addr] <= i_slot_wr.byte_data;
        end
        if (i_slot_wr.meta_en) begin
            r_mem_sender[i_slot_wr.meta_slot] <= i_slot_wr.sender;
            r_mem_kind[i_slot_wr.meta_slot]   <= i_slot_wr.kind;
            r_mem_len[i_slot_wr.meta_slot]    <= i_slot_wr.length;
        end
        if (meta_rd) begin
            r_meta_sender <= r_mem_sender[i_q_head.slot];
            r_meta_kind   <= r_mem_kind[i_q_head.slot];
            r_meta_len    <= r_mem_len[i_q_head.slot];
        end
        if (rd_en) begin
            r_rd_data <= r_mem_bytes[byte_addr(r_slot, r_idx[IDX_W-1:0])];
        end
    end

endmodule

/* rtl/core/message_mailbox_fifo.sv */
// Message mailbox top: a ring of message slots fed by a byte stream.
// Push items are taken one per cycle while full is low; a closing item's status passes
// the command queue and issue register. A pop reads metadata, then a byte per cycle while
// the output buffer has room; full stays high until its last byte is read from the store.
// Reset (i_rst_n low, synchronous) empties the ring, queue and output; slot stores
// keep their contents and need no clearing pass.
module message_mailbox_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input side
    input  logic                         push,
    output logic                         full,
    input  logic                         i_cmd,
    input  logic [mmf_pkg::SND_W-1:0]    i_sender_id,
    input  logic signed [mmf_pkg::KIND_W-1:0] i_message_kind,
    input  logic [mmf_pkg::BYTE_W-1:0]   i_payload_byte,
    input  logic                         i_byte_present,
    input  logic                         i_final_item,
    input  logic [mmf_pkg::LEN_W-1:0]    i_receive_capacity,
    // Result side
    output logic                         empty,
    input  logic                         pop,
    output logic [1:0]                   o_status,
    output logic [mmf_pkg::SND_W-1:0]    o_out_sender_id,
    output logic signed [mmf_pkg::KIND_W-1:0] o_out_kind,
    output logic [mmf_pkg::LEN_W-1:0]    o_delivered_length,
    output logic [mmf_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                         o_out_byte_valid,
    output logic                         o_last_result
);
    import mmf_pkg::*;

    logic     q_full;
    logic     q_empty;
    logic     q_wr;
    logic     q_rd;
    t_cmd     q_wr_data;
    t_cmd     q_head;
    t_slot_wr slot_wr;
    logic     pop_done;
    t_result  result;

    // Front: take items, write bytes into the open slot, classify each item.
    mmf_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .o_full             (full),
        .i_cmd              (i_cmd),
        .i_sender_id        (i_sender_id),
        .i_message_kind     (i_message_kind),
        .i_payload_byte     (i_payload_byte),
        .i_byte_present     (i_byte_present),
        .i_final_item       (i_final_item),
        .i_receive_capacity (i_receive_capacity),
        .i_q_full           (q_full),
        .o_q_wr             (q_wr),
        .o_q_data           (q_wr_data),
        .o_slot_wr          (slot_wr),
        .i_pop_done         (pop_done)
    );

    // Decouple: statuses and deliveries wait here in program order.
    mmf_cmd_queue u_cmd_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (q_wr),
        .i_wr_data (q_wr_data),
        .i_rd_en   (q_rd),
        .o_rd_data (q_head),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    // Back: read slot stores, emit one result per cycle into the output buffer while it has room.
    mmf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_slot_wr  (slot_wr),
        .i_q_head   (q_head),
        .i_q_empty  (q_empty),
        .o_q_rd     (q_rd),
        .o_pop_done (pop_done),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (result)
    );

    assign o_status           = result.status;
    assign o_out_sender_id    = result.sender;
    assign o_out_kind         = $signed(result.kind);
    assign o_delivered_length = result.dlen;
    assign o_out_byte         = result.data;
    assign o_out_byte_valid   = result.data_valid;
    assign o_last_result      = result.last;

endmodule

/* rtl/core/mmf_checker.sv */
// Port-level checks for the message mailbox, bound to its top level.
// Depends on mmf_pkg and message_mailbox_fifo_assert.svh.
`include "message_mailbox_fifo_assert.svh"

module mmf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         push,
    input logic                         full,
    input logic                         i_cmd,
    input logic [mmf_pkg::SND_W-1:0]    i_sender_id,
    input logic signed [mmf_pkg::KIND_W-1:0] i_message_kind,
    input logic [mmf_pkg::BYTE_W-1:0]   i_payload_byte,
    input logic                         i_byte_present,
    input logic                         i_final_item,
    input logic [mmf_pkg::LEN_W-1:0]    i_receive_capacity,
    input logic                         empty,
    input logic                         pop,
    input logic [1:0]                   o_status,
    input logic [mmf_pkg::SND_W-1:0]    o_out_sender_id,
    input logic signed [mmf_pkg::KIND_W-1:0] o_out_kind,
    input logic [mmf_pkg::LEN_W-1:0]    o_delivered_length,
    input logic [mmf_pkg::BYTE_W-1:0]   o_out_byte,
    input logic                         o_out_byte_valid,
    input logic                         o_last_result
);
    import mmf_pkg::*;

    `MMF_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (empty && !full), "reset left results or stall")
    `MMF_ASSERT(a_hold_result, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_out_byte) && $stable(o_last_result)), "waiting result changed")
    `MMF_ASSERT(a_byte_is_ok, i_clk, i_rst_n, (!empty && o_out_byte_valid) |-> (o_status == 2'(ST_OK) && o_delivered_length != '0), "payload byte on a bad result")
    `MMF_ASSERT(a_reject_single, i_clk, i_rst_n, (!empty && o_status != 2'(ST_OK)) |-> (o_last_result && !o_out_byte_valid && o_delivered_length == '0 && o_out_sender_id == '0), "status result not a lone item")

endmodule

bind message_mailbox_fifo mmf_checker u_mmf_checker (.*);

/* tb/sv/testbench.sv */
// Self-checking bench for the message mailbox ring: streams messages and pops
// through the queue handshakes and checks every delivered item against a predictor.
// Depends on mmf_pkg (sizes, status and command codes, result struct) and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mmf_pkg::*;

    localparam int RESET_CYCLES    = 6;
    localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off for the backpressure test
    localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no item taken on either side
    localparam int SETTLE_CYCLES   = 72;    // settle time before the final verdict
    localparam int REPORT_LIMIT    = 10;

    // One input item as it crosses the push handshake.
    typedef struct packed {
        t_cmd_code             cmd;
        logic [SND_W-1:0]      sender;
        logic [KIND_W-1:0]     kind;
        logic [BYTE_W-1:0]     data;
        logic                  present;
        logic                  fin;
        logic [LEN_W-1:0]      cap;
    } t_mail_item;

    // Clock, reset and block ports; every input is known from time zero.
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      push = 1'b0;
    logic                      full;
    logic                      i_cmd = 1'b0;
    logic [SND_W-1:0]          i_sender_id = '0;
    logic signed [KIND_W-1:0]  i_message_kind = '0;
    logic [BYTE_W-1:0]         i_payload_byte = '0;
    logic                      i_byte_present = 1'b0;
    logic                      i_final_item = 1'b0;
    logic [LEN_W-1:0]          i_receive_capacity = '0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic [1:0]                o_status;
    logic [SND_W-1:0]          o_out_sender_id;
    logic signed [KIND_W-1:0]  o_out_kind;
    logic [LEN_W-1:0]          o_delivered_length;
    logic [BYTE_W-1:0]         o_out_byte;
    logic                      o_out_byte_valid;
    logic                      o_last_result;

    // Predicted mailbox contents, kept apart from the block.
    logic [BYTE_W-1:0]         ring_bytes  [SLOTS*MSG_BYTES];
    logic [SND_W-1:0]          ring_sender [SLOTS];
    logic [KIND_W-1:0]         ring_kind   [SLOTS];
    logic [LEN_W-1:0]          ring_len    [SLOTS];
    logic [SLOT_W-1:0]         head_slot = '0;
    logic [SLOT_W-1:0]         tail_slot = '0;
    int                        open_count = 0;

    t_result                   mailbox_results_due[$];

    int                        items_sent = 0;
    int                        failures = 0;
    int                        idle_cycles = 0;
    int                        sender_idle_pct = 0;
    int                        receiver_stall_pct = 0;
    int                        hold_off_cycles = 0;

    message_mailbox_fifo dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_cmd              (i_cmd),
        .i_sender_id        (i_sender_id),
        .i_message_kind     (i_message_kind),
        .i_payload_byte     (i_payload_byte),
        .i_byte_present     (i_byte_present),
        .i_final_item       (i_final_item),
        .i_receive_capacity (i_receive_capacity),
        .empty              (empty),
        .pop                (pop),
        .o_status           (o_status),
        .o_out_sender_id    (o_out_sender_id),
        .o_out_kind         (o_out_kind),
        .o_delivered_length (o_delivered_length),
        .o_out_byte         (o_out_byte),
        .o_out_byte_valid   (o_out_byte_valid),
        .o_last_result      (o_last_result)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Advance the predicted mailbox by one accepted item and queue what it must emit.
    function automatic void mailbox_apply(input t_mail_item it);
        t_result           r;
        int                n;
        int                base;
        logic [SLOT_W-1:0] next_slot;
        r = '0;
        r.last = 1'b1;
        if (it.cmd == CMD_PUSH) begin
            // Store present bytes while there is room; the count saturates one past full.
            if (it.present) begin
                if (open_count < MSG_BYTES)
                    ring_bytes[int'(head_slot) * MSG_BYTES + open_count] = it.data;
                if (open_count <= MSG_BYTES)
                    open_count++;
            end
            if (!it.fin)
                return;
            // Closing item: length is checked before room; one slot always stays unused.
            next_slot = SLOT_W'((int'(head_slot) + 1) % SLOTS);
            if (open_count > MSG_BYTES) begin
                r.status = ST_TOO_LONG;
            end else if (next_slot == tail_slot) begin
                r.status = ST_FULL;
            end else begin
                ring_sender[head_slot] = it.sender;
                ring_kind[head_slot]   = it.kind;
                ring_len[head_slot]    = LEN_W'(open_count);
                head_slot = next_slot;
                r.status = ST_OK;
            end
            open_count = 0;
            mailbox_results_due.push_back(r);
        end else if (head_slot == tail_slot) begin
            r.status = ST_EMPTY;
            mailbox_results_due.push_back(r);
        end else begin
            // Deliver min(length, capacity) bytes of the oldest message; drop the rest.
            n = int'(ring_len[tail_slot]);
            if (n > int'(it.cap))
                n = int'(it.cap);
            if (n > MSG_BYTES)
                n = MSG_BYTES;
            base = int'(tail_slot) * MSG_BYTES;
            r.status = ST_OK;
            r.sender = ring_sender[tail_slot];
            r.kind   = ring_kind[tail_slot];
            r.dlen   = LEN_W'(n);
            tail_slot = SLOT_W'((int'(tail_slot) + 1) % SLOTS);
            if (n == 0) begin
                mailbox_results_due.push_back(r);
            end else begin
                for (int i = 0; i < n; i++) begin
                    r.data       = ring_bytes[base + i];
                    r.data_valid = 1'b1;
                    r.last       = (i == n - 1);
                    mailbox_results_due.push_back(r);
                end
            end
        end
    endfunction

    task automatic report_result_error(input string what, input t_result want,
                                       input t_result got);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%0t %s: want st=%0d snd=%h kind=%h len=%0d byte=%h v=%b last=%b",
                     $realtime, what, want.status, want.sender, want.kind, want.dlen,
                     want.data, want.data_valid, want.last);
        if (failures <= REPORT_LIMIT)
            $display("%0t %s:  got st=%0d snd=%h kind=%h len=%0d byte=%h v=%b last=%b",
                     $realtime, what, got.status, got.sender, got.kind, got.dlen,
                     got.data, got.data_valid, got.last);
    endtask

    // Sample both handshakes on the edge: check results first, then predict the
    // accepted input. A new input never affects a result taken at the same edge.
    always @(posedge i_clk) begin
        t_result    seen;
        t_result    want;
        t_mail_item taken;
        if (i_rst_n && pop && !empty) begin
            seen.status     = t_status'(o_status);
            seen.sender     = o_out_sender_id;
            seen.kind       = o_out_kind;
            seen.dlen       = o_delivered_length;
            seen.data       = o_out_byte;
            seen.data_valid = o_out_byte_valid;
            seen.last       = o_last_result;
            if (mailbox_results_due.size() == 0) begin
                report_result_error("unexpected item", '0, seen);
            end else begin
                want = mailbox_results_due.pop_front();
                if (want.status !== seen.status || want.sender !== seen.sender ||
                    want.kind !== seen.kind || want.dlen !== seen.dlen ||
                    want.data !== seen.data || want.data_valid !== seen.data_valid ||
                    want.last !== seen.last)
                    report_result_error("mismatch", want, seen);
            end
        end
        if (i_rst_n && push && !full) begin
            taken.cmd     = t_cmd_code'(i_cmd);
            taken.sender  = i_sender_id;
            taken.kind    = i_message_kind;
            taken.data    = i_payload_byte;
            taken.present = i_byte_present;
            taken.fin     = i_final_item;
            taken.cap     = i_receive_capacity;
            mailbox_apply(taken);
        end
        // Watchdog: give up once nothing has moved on either side for too long.
        if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: hold off for a counted stretch on request, otherwise stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            pop <= 1'b0;
            hold_off_cycles--;
        end else begin
            pop <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Mostly short messages; a few right at, just past and well past the byte limit.
    function automatic int random_length();
        int r;
        r = $urandom_range(99);
        if (r < 78)
            return $urandom_range(6);
        if (r < 92)
            return $urandom_range(40, 7);
        if (r < 97)
            return $urandom_range(MSG_BYTES + 2, MSG_BYTES - 2);
        return $urandom_range(MSG_BYTES + 8, MSG_BYTES + 3);
    endfunction

    // Capacity covers zero, small values, the limit and values above it.
    function automatic int random_capacity();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return $urandom_range(4);
        if (r < 80)
            return $urandom_range(MSG_BYTES);
        return $urandom_range((1 << LEN_W) - 1, MSG_BYTES + 1);
    endfunction

    // Offer one item, idling at random first, and return at the edge that takes it.
    // Leave push high so back-to-back items need no gap.
    task automatic send_item(input t_mail_item it);
        while ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push               <= 1'b1;
        i_cmd              <= it.cmd;
        i_sender_id        <= it.sender;
        i_message_kind     <= it.kind;
        i_payload_byte     <= it.data;
        i_byte_present     <= it.present;
        i_final_item       <= it.fin;
        i_receive_capacity <= it.cap;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_push(input logic [SND_W-1:0] snd, input logic [KIND_W-1:0] knd,
                             input logic [BYTE_W-1:0] data, input logic present,
                             input logic fin);
        t_mail_item it;
        it.cmd     = CMD_PUSH;
        it.sender  = snd;
        it.kind    = knd;
        it.data    = data;
        it.present = present;
        it.fin     = fin;
        it.cap     = LEN_W'($urandom);
        send_item(it);
    endtask

    // Pop ignores every field but the capacity; randomize the rest anyway.
    task automatic send_pop(input int cap);
        t_mail_item it;
        it         = t_mail_item'({$urandom, $urandom, $urandom});
        it.cmd     = CMD_POP;
        it.cap     = LEN_W'(cap);
        send_item(it);
    endtask

    // Stream one message of len bytes. With noise, mix in ignored filler items,
    // pops in the middle, and sometimes close with a filler item instead of a byte.
    task automatic send_message(input logic [SND_W-1:0] snd, input logic [KIND_W-1:0] knd,
                                input int len, input bit noisy);
        bit filler_close;
        filler_close = noisy && len > 0 && $urandom_range(99) < 15;
        for (int k = 0; k < len; k++) begin
            if (noisy && $urandom_range(99) < 8)
                send_push(snd, knd, BYTE_W'($urandom), 1'b0, 1'b0);
            if (noisy && $urandom_range(99) < 3)
                send_pop(random_capacity());
            send_push(snd, knd, BYTE_W'($urandom), 1'b1, (k == len - 1) && !filler_close);
        end
        if (len == 0 || filler_close)
            send_push(snd, knd, BYTE_W'($urandom), 1'b0, 1'b1);
    endtask

    // Drop push, let the last accepted item be predicted, then hold until every
    // predicted item has been taken.
    task automatic wait_until_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (mailbox_results_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Pop an empty ring at both capacity extremes.
    task automatic test_empty_pop();
        send_pop(0);
        send_pop((1 << LEN_W) - 1);
    endtask

    // Zero-length messages, pops that deliver nothing, truncated and oversized capacity,
    // and sender, kind and byte at both ends of their ranges.
    task automatic test_capacity_edges();
        send_push('0, {1'b1, {(KIND_W-1){1'b0}}}, '0, 1'b0, 1'b1);
        send_pop(MSG_BYTES);
        send_push('1, {1'b0, {(KIND_W-1){1'b1}}}, '1, 1'b1, 1'b1);
        send_pop(0);
        send_push('1, '1, '0, 1'b1, 1'b1);
        send_pop(1);
        send_message(SND_W'($urandom), $urandom, 3, 1'b0);
        send_pop(1);
        send_message(SND_W'($urandom), $urandom, 2, 1'b0);
        send_pop((1 << LEN_W) - 1);
    endtask

    // Exactly full, one byte over, well over (count saturates), then recovery.
    task automatic test_length_limits();
        send_message(SND_W'($urandom), $urandom, MSG_BYTES, 1'b0);
        send_pop(MSG_BYTES);
        send_message(SND_W'($urandom), $urandom, MSG_BYTES + 1, 1'b0);
        send_message(SND_W'($urandom), $urandom, MSG_BYTES + 6, 1'b0);
        send_message(SND_W'($urandom), $urandom, 1, 1'b0);
        send_pop(MSG_BYTES);
    endtask

    // Fill the ring past its usable depth, then drain it and pop once more.
    task automatic test_ring_full();
        repeat (SLOTS) send_message(SND_W'($urandom), $urandom, 0, 1'b0);
        repeat (SLOTS) send_pop(random_capacity());
    endtask

    // Pop while a message is half streamed in; the open message must survive.
    task automatic test_pop_during_push();
        logic [SND_W-1:0]  snd;
        logic [KIND_W-1:0] knd;
        snd = SND_W'($urandom);
        knd = $urandom;
        send_message(SND_W'($urandom), $urandom, 2, 1'b0);
        send_push(snd, knd, BYTE_W'($urandom), 1'b1, 1'b0);
        send_push(snd, knd, BYTE_W'($urandom), 1'b1, 1'b0);
        send_pop(MSG_BYTES);
        send_pop(MSG_BYTES);
        send_push(snd, knd, BYTE_W'($urandom), 1'b1, 1'b1);
        send_pop(MSG_BYTES);
        wait_until_drained();
    endtask

    // Hold the receiver off while the sender keeps offering, so the block backs up.
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_cycles    = HOLD_OFF_CYCLES;
        repeat (12) begin
            send_message(SND_W'($urandom), $urandom, $urandom_range(3), 1'b0);
            send_pop(MSG_BYTES);
        end
        wait_until_drained();
    endtask

    // Random mix of well-formed messages with noise, and pops, under one idling pattern.
    task automatic test_random_traffic(input int n_items, input int s_idle, input int r_stall);
        int stop_at;
        sender_idle_pct    = s_idle;
        receiver_stall_pct = r_stall;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 58)
                send_message(SND_W'($urandom), $urandom, random_length(), 1'b1);
            else
                send_pop(random_capacity());
        end
        wait_until_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pop();
        test_capacity_edges();
        test_length_limits();
        test_ring_full();
        test_pop_during_push();
        test_backpressure();
        test_random_traffic(45, 0, 0);
        test_random_traffic(45, 51, 0);
        test_random_traffic(45, 0, 51);
        test_random_traffic(45, 9, 9);

        // Let any stray item surface before judging.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0 && mailbox_results_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
